[hw/rtl/dse_pkg.sv]
// Shared types, constants and compare helpers for the delimited substring extractor.
// Depends on nothing; every other file of the block uses it by scoped names.

package dse_pkg;

    localparam int MAX_DELIM_BYTES = 8;
    localparam int WIN_W           = 8 * MAX_DELIM_BYTES;
    localparam int CNT_W           = $clog2(MAX_DELIM_BYTES + 1);
    localparam int LANE_W          = (MAX_DELIM_BYTES > 1) ? $clog2(MAX_DELIM_BYTES) : 1;
    localparam int PAT_W           = 64;
    localparam int LEN_W           = 4;
    localparam int CFG_W           = 64;
    localparam int CFG_ADDR_W      = 2;
    localparam int FIFO_DEPTH      = 2;
    localparam int FIFO_AW         = (FIFO_DEPTH > 1) ? $clog2(FIFO_DEPTH) : 1;
    localparam int FIFO_CW         = $clog2(FIFO_DEPTH + 1);

    // Configuration register indexes.
    localparam logic [CFG_ADDR_W-1:0] CFG_BEGIN_PATTERN = 2'd0;
    localparam logic [CFG_ADDR_W-1:0] CFG_BEGIN_LENGTH  = 2'd1;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_PATTERN   = 2'd2;
    localparam logic [CFG_ADDR_W-1:0] CFG_END_LENGTH    = 2'd3;

    typedef enum logic [1:0] {
        KIND_CONTENT  = 2'd0,
        KIND_COMPLETE = 2'd1,
        KIND_NOTFOUND = 2'd2
    } kind_t;

    typedef struct packed {
        logic [7:0] data;
        kind_t      kind;
        logic       last;
    } res_t;

    // Clamp a raw length register to the range 1..MAX_DELIM_BYTES.
    function automatic logic [CNT_W-1:0] eff_len(input logic [LEN_W-1:0] raw);
        logic [CNT_W-1:0] r;
        if (raw == '0)
            r = CNT_W'(1);
        else if (32'(raw) > MAX_DELIM_BYTES)
            r = CNT_W'(MAX_DELIM_BYTES);
        else
            r = CNT_W'(raw);
        return r;
    endfunction

    // The newest n window bytes equal the first n pattern bytes, oldest first.
    function automatic logic window_match(input logic [WIN_W-1:0] win,
                                          input logic [PAT_W-1:0] pat,
                                          input logic [CNT_W-1:0] n);
        logic             ok;
        logic [LANE_W-1:0] lane;
        ok = 1'b1;
        for (int i = 0; i < MAX_DELIM_BYTES; i++)
        begin
            lane = LANE_W'(n - CNT_W'(i) - CNT_W'(1));
            if ((CNT_W'(i) < n) && (win[8*lane +: 8] != pat[8*i +: 8]))
                ok = 1'b0;
        end
        return ok;
    endfunction

endpackage

[hw/rtl/dse_front.sv]
// Front part: configuration registers, byte window and phase tracking.
// Classifies each accepted item and pushes at most one result. Uses dse_pkg.

module dse_front (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [dse_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dse_pkg::CFG_W-1:0]       cfg_wdata,
    input  logic                            in_fire,
    input  logic [7:0]                      in_byte,
    input  logic                            in_last,
    output logic                            push,
    output dse_pkg::res_t                   push_res
);

    typedef enum logic [1:0] {
        PH_SEEK    = 2'd0,
        PH_EXTRACT = 2'd1,
        PH_DONE    = 2'd2
    } phase_t;

    logic [dse_pkg::PAT_W-1:0] begin_pat_reg;
    logic [dse_pkg::LEN_W-1:0] begin_len_reg;
    logic [dse_pkg::PAT_W-1:0] end_pat_reg;
    logic [dse_pkg::LEN_W-1:0] end_len_reg;

    phase_t                    phase_reg, phase_next;
    logic [dse_pkg::WIN_W-1:0] win_reg, win_next;
    logic [dse_pkg::CNT_W-1:0] held_reg, held_next;

    logic [dse_pkg::WIN_W-1:0] win_shift;
    logic [dse_pkg::CNT_W-1:0] held_inc;
    logic [dse_pkg::CNT_W-1:0] bl, el, el_m1;
    logic                      begin_hit, end_hit;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            begin_pat_reg <= '0;
            begin_len_reg <= dse_pkg::LEN_W'(1);
            end_pat_reg   <= '0;
            end_len_reg   <= dse_pkg::LEN_W'(1);
        end
        else if (cfg_we)
        begin
            unique case (cfg_addr)
                dse_pkg::CFG_BEGIN_PATTERN: begin_pat_reg <= cfg_wdata;
                dse_pkg::CFG_BEGIN_LENGTH:  begin_len_reg <= cfg_wdata[dse_pkg::LEN_W-1:0];
                dse_pkg::CFG_END_PATTERN:   end_pat_reg   <= cfg_wdata;
                dse_pkg::CFG_END_LENGTH:    end_len_reg   <= cfg_wdata[dse_pkg::LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        win_shift = {win_reg[dse_pkg::WIN_W-9:0], in_byte};
        held_inc  = (32'(held_reg) < dse_pkg::MAX_DELIM_BYTES) ?
                    held_reg + dse_pkg::CNT_W'(1) : held_reg;
        bl        = dse_pkg::eff_len(begin_len_reg);
        el        = dse_pkg::eff_len(end_len_reg);
        el_m1     = el - dse_pkg::CNT_W'(1);
        begin_hit = (held_inc >= bl) && dse_pkg::window_match(win_shift, begin_pat_reg, bl);
        end_hit   = (held_inc >= el) && dse_pkg::window_match(win_shift, end_pat_reg, el);
    end

    always_comb
    begin
        phase_next    = phase_reg;
        win_next      = win_reg;
        held_next     = held_reg;
        push          = 1'b0;
        push_res.data = '0;
        push_res.kind = dse_pkg::KIND_CONTENT;
        push_res.last = 1'b0;
        if (in_fire)
        begin
            unique case (phase_reg)
                PH_DONE:
                begin
                    // The rest of the text is ignored until its final byte.
                    if (in_last)
                    begin
                        phase_next = PH_SEEK;
                        win_next   = '0;
                        held_next  = '0;
                    end
                end
                PH_EXTRACT:
                begin
                    win_next  = win_shift;
                    held_next = held_inc;
                    if (end_hit)
                    begin
                        phase_next    = in_last ? PH_SEEK : PH_DONE;
                        win_next      = '0;
                        held_next     = '0;
                        push          = 1'b1;
                        push_res.kind = dse_pkg::KIND_COMPLETE;
                        push_res.last = 1'b1;
                    end
                    else if (in_last)
                    begin
                        phase_next    = PH_SEEK;
                        win_next      = '0;
                        held_next     = '0;
                        push          = 1'b1;
                        push_res.kind = dse_pkg::KIND_NOTFOUND;
                        push_res.last = 1'b1;
                    end
                    else if (held_inc > el_m1)
                    begin
                        // The oldest held byte can no longer be part of the end delimiter.
                        held_next     = el_m1;
                        push          = 1'b1;
                        push_res.data = win_shift[8*el_m1[dse_pkg::LANE_W-1:0] +: 8];
                    end
                end
                default:
                begin
                    win_next  = win_shift;
                    held_next = held_inc;
                    if (begin_hit)
                    begin
                        phase_next = PH_EXTRACT;
                        win_next   = '0;
                        held_next  = '0;
                    end
                    else
                    begin
                        phase_next = PH_SEEK;
                    end
                    if (in_last)
                    begin
                        phase_next    = PH_SEEK;
                        win_next      = '0;
                        held_next     = '0;
                        push          = 1'b1;
                        push_res.kind = dse_pkg::KIND_NOTFOUND;
                        push_res.last = 1'b1;
                    end
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_SEEK;
            win_reg   <= '0;
            held_reg  <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            win_reg   <= win_next;
            held_reg  <= held_next;
        end
    end

endmodule

[hw/rtl/dse_fifo.sv]
// Short result queue between the front and back parts.
// Holds dse_pkg::res_t entries; uses dse_pkg for depth and types.

module dse_fifo (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  dse_pkg::res_t push_res,
    output logic          full,
    input  logic          pop,
    output logic          nonempty,
    output dse_pkg::res_t head
);

    dse_pkg::res_t                  mem_reg [dse_pkg::FIFO_DEPTH];
    logic [dse_pkg::FIFO_AW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [dse_pkg::FIFO_AW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [dse_pkg::FIFO_CW-1:0]    count_reg, count_next;
    logic                           do_push, do_pop;

    assign full     = (32'(count_reg) == dse_pkg::FIFO_DEPTH);
    assign nonempty = (count_reg != '0);
    assign head     = mem_reg[rd_ptr_reg];
    assign do_push  = push && !full;
    assign do_pop   = pop && nonempty;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (32'(wr_ptr_reg) == dse_pkg::FIFO_DEPTH - 1) ?
                          '0 : wr_ptr_reg + dse_pkg::FIFO_AW'(1);
        if (do_pop)
            rd_ptr_next = (32'(rd_ptr_reg) == dse_pkg::FIFO_DEPTH - 1) ?
                          '0 : rd_ptr_reg + dse_pkg::FIFO_AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + dse_pkg::FIFO_CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - dse_pkg::FIFO_CW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= push_res;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[hw/rtl/dse_back.sv]
// Back part: output register that drains the result queue onto the master side.
// Uses dse_pkg::res_t.

module dse_back (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          q_nonempty,
    input  dse_pkg::res_t q_head,
    output logic          q_pop,
    output logic          out_valid,
    input  logic          out_ready,
    output dse_pkg::res_t out_res
);

    logic          valid_reg, valid_next;
    dse_pkg::res_t res_reg;

    // Refill whenever the register is empty or its item leaves this cycle.
    assign q_pop      = q_nonempty && (!valid_reg || out_ready);
    assign valid_next = q_pop || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            valid_reg <= 1'b0;
        else
            valid_reg <= valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
            res_reg <= q_head;
    end

endmodule

[hw/rtl/delimited_substring_extractor.sv]
// Path: a result reaches the master side through the result queue, then the output register.
// Throughput: one item per cycle; the two-entry result queue and output register
// absorb output stalls, and the input stalls only when the queue is full.
// Reset (rst_n low, asynchronous) returns to seeking with an empty window, empties
// the queue and output register, and sets both delimiters to one zero byte.
// Top level: instantiates dse_front, dse_fifo and dse_back; uses dse_pkg.

module delimited_substring_extractor (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    input  logic [7:0]                      s_tdata,   // [7:0] text_byte
    input  logic                            s_tlast,   // text_end
    output logic                            m_tvalid,
    input  logic                            m_tready,
    output logic [7:0]                      m_tdata,   // [7:0] result_byte
    output logic [1:0]                      m_tuser,   // [1:0] result_kind
    output logic                            m_tlast,   // result_last
    input  logic                            cfg_we,
    input  logic [dse_pkg::CFG_ADDR_W-1:0]  cfg_addr,
    input  logic [dse_pkg::CFG_W-1:0]       cfg_wdata
);

    logic          in_fire;
    logic          push;
    dse_pkg::res_t push_res;
    logic          q_full;
    logic          q_pop;
    logic          q_nonempty;
    dse_pkg::res_t q_head;
    dse_pkg::res_t out_res;

    assign s_tready = !q_full;
    assign in_fire  = s_tvalid && s_tready;

    dse_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata),
        .in_fire   (in_fire),
        .in_byte   (s_tdata),
        .in_last   (s_tlast),
        .push      (push),
        .push_res  (push_res)
    );

    dse_fifo u_fifo (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_res (push_res),
        .full     (q_full),
        .pop      (q_pop),
        .nonempty (q_nonempty),
        .head     (q_head)
    );

    dse_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .q_nonempty (q_nonempty),
        .q_head     (q_head),
        .q_pop      (q_pop),
        .out_valid  (m_tvalid),
        .out_ready  (m_tready),
        .out_res    (out_res)
    );

    assign m_tdata = out_res.data;
    assign m_tuser = out_res.kind;
    assign m_tlast = out_res.last;

endmodule

[hw/rtl/dse_checker.sv]
// Port-level checker for delimited_substring_extractor, attached by bind.
// Uses dse_pkg for result kind codes.

module dse_checker (
    input logic       clk,
    input logic       rst_n,
    input logic       s_tready,
    input logic       m_tvalid,
    input logic       m_tready,
    input logic [7:0] m_tdata,
    input logic [1:0] m_tuser,
    input logic       m_tlast
);

    // A held result keeps its payload until taken.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
                                 && $stable(m_tlast))
        else $error("stalled result changed");

    // Status results close the text and carry a zero byte.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != dse_pkg::KIND_CONTENT) |-> m_tlast && (m_tdata == 8'd0))
        else $error("status result malformed");

    // Content bytes never close the text.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == dse_pkg::KIND_CONTENT) |-> !m_tlast)
        else $error("content result marked last");

    // The input stalls only while the output register holds a result.
    assert property (@(posedge clk) disable iff (!rst_n)
        !s_tready |-> m_tvalid)
        else $error("input stalled with empty output");

endmodule

bind delimited_substring_extractor dse_checker u_dse_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);
